// ===== rtl/sidu_pkg.sv =====
// shared constants for the signed divider unit
// no dependencies; imported by the top level and its checker
package sidu_pkg;

  // register stages around the bit steps: operand magnitude stage and output register
  localparam int unsigned SIDU_EXTRA_STAGES = 2;

endpackage

// ===== rtl/signed_int32_divider_unit.sv =====
// an accepted item passes the magnitude stage, each bit-step stage and the output register before out_valid
// throughput: one item per cycle when not stalled; one restoring compare-subtract per bit in its own stage
// stall from the output ripples back only through occupied stages, so bubbles are filled
// zero divisor and minimum divided by minus one give the largest positive value
// reset (rst, synchronous) clears all stage valid bits; data registers are not reset
// signed pipelined restoring divider, one bit step per register stage
// depends on sidu_pkg
module signed_int32_divider_unit
  import sidu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] quotient
);

  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned NSTG = W + SIDU_EXTRA_STAGES;
  localparam logic [W-1:0] TOP_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

  // stage 0 holds magnitudes, stages 1..W hold bit steps, stage W+1 is the output
  logic [NSTG-1:0] valid;
  logic [NSTG-1:0] load;
  logic [W-1:0]    rem [0:W];
  logic [W-1:0]    dq  [0:W];
  logic [W-1:0]    dm  [0:W];
  logic            neg [0:W];

  logic [W-1:0] dividend_mag;
  logic [W-1:0] divisor_mag;
  logic [W-1:0] q_mag;
  logic [W-1:0] quotient_next;

  // a stage loads when it is empty or its content moves on
  assign load[NSTG-1] = !valid[NSTG-1] || !out_stall;
  generate
    for (genvar s = 0; s < NSTG - 1; s++) begin : g_load
      assign load[s] = !valid[s] || load[s+1];
    end
  endgenerate

  assign in_stall  = !load[0];
  assign out_valid = valid[NSTG-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (load[s]) begin
          valid[s] <= valid[s-1];
        end
      end
    end
  end

  // operand magnitudes
  assign dividend_mag = dividend[W-1] ? (~dividend + 1'b1) : dividend;
  assign divisor_mag  = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      rem[0] <= '0;
      dq[0]  <= dividend_mag;
      dm[0]  <= divisor_mag;
      neg[0] <= dividend[W-1] ^ divisor[W-1];
    end
  end

  // bit steps: shift in the next dividend bit, subtract when it fits
  generate
    for (genvar k = 1; k <= W; k++) begin : g_step
      logic [W-1:0] trial;
      logic         fits;
      assign trial = {rem[k-1][W-2:0], dq[k-1][W-1]};
      assign fits  = (trial >= dm[k-1]);
      always_ff @(posedge clk) begin
        if (load[k]) begin
          rem[k] <= fits ? (trial - dm[k-1]) : trial;
          dq[k]  <= {dq[k-1][W-2:0], fits};
          dm[k]  <= dm[k-1];
          neg[k] <= neg[k-1];
        end
      end
    end
  endgenerate

  // sign correction and saturation
  assign q_mag = dq[W];
  always_comb begin
    if (neg[W]) begin
      quotient_next = (q_mag > TOP_VAL) ? MAX_POS : (~q_mag + 1'b1);
    end else begin
      quotient_next = (q_mag > MAX_POS) ? MAX_POS : q_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (load[NSTG-1]) begin
      quotient <= quotient_next;
    end
  end

endmodule

// ===== rtl/sidu_checker.sv =====
// port-level checker for the signed divider unit, with its bind
// depends on sidu_pkg and signed_int32_divider_unit
module sidu_checker
  import sidu_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [DATA_WIDTH-1:0] dividend,
  input logic [DATA_WIDTH-1:0] divisor,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] quotient
);

  // output empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a free output never holds back the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("in_stall while output is free");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(quotient))
    else $error("stalled item changed or dropped");

  // an item only leaves when it is taken
  a_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> !$past(out_stall))
    else $error("item left while stalled");

  // a stalled input item stays on the ports unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(dividend) && $stable(divisor))
    else $error("stalled input item changed or dropped");

endmodule

bind signed_int32_divider_unit sidu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sidu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .dividend  (dividend),
  .divisor   (divisor),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .quotient  (quotient)
);

// ===== dv/tb_signed_int32_divider_unit.sv =====
// self-checking testbench for the signed pipelined restoring divider
// depends on sidu_pkg and signed_int32_divider_unit; quotients predicted by a bit-step model
module tb_signed_int32_divider_unit;
  import sidu_pkg::*;

  localparam int unsigned W = 32;
  localparam logic [W-1:0] INT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] INT_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};
  localparam int unsigned TAIL_CYCLES = 4 * (W + SIDU_EXTRA_STAGES);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_PRINTS = 200;

  typedef struct {
    logic [W-1:0] dvd;
    logic [W-1:0] dvs;
    bit           quiet;
  } div_op_t;

  typedef struct {
    logic [W-1:0] dvd;
    logic [W-1:0] dvs;
    logic [W-1:0] quo;
  } quotient_due_t;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_stall;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;
  logic         out_valid;
  logic         out_stall;
  logic [W-1:0] quotient;

  div_op_t       ops_waiting[$];
  quotient_due_t quotients_due[$];
  bit            in_taken;
  bit            cur_quiet;
  int            gap_left;
  int            stall_left;
  int            mismatches;
  int unsigned   cycle_count;

  signed_int32_divider_unit #(
    .DATA_WIDTH(W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dividend (dividend),
    .divisor  (divisor),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .quotient (quotient)
  );

  // restoring division on magnitudes, sign fix-up and saturation
  function automatic logic [W-1:0] predict_quotient(logic [W-1:0] dvd, logic [W-1:0] dvs);
    logic [63:0] rem;
    logic [63:0] den;
    logic [63:0] mag_q;
    logic        signs_differ;
    signs_differ = dvd[W-1] ^ dvs[W-1];
    rem = {32'b0, dvd[W-1] ? (~dvd + 1'b1) : dvd};
    den = {32'b0, dvs[W-1] ? (~dvs + 1'b1) : dvs};
    mag_q = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if ((rem >> i) >= den) begin
        mag_q[i] = 1'b1;
        rem = rem - (den << i);
      end
    end
    if (signs_differ) begin
      // magnitude of exactly 2^(W-1) still fits as the minimum value
      if (mag_q > {32'b0, INT_MIN}) return INT_MAX;
      return ~mag_q[W-1:0] + 1'b1;
    end
    if (mag_q > {32'b0, INT_MAX}) return INT_MAX;
    return mag_q[W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] dvd, logic [W-1:0] dvs,
                                 logic [W-1:0] got, logic [W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch %0s: %0d / %0d got %0d (%h) want %0d (%h)", what,
               $signed(dvd), $signed(dvs), $signed(got), got, $signed(want), want);
  endtask

  task automatic add_item(logic [W-1:0] dvd, logic [W-1:0] dvs, bit quiet);
    div_op_t op;
    op.dvd = dvd;
    op.dvs = dvs;
    op.quiet = quiet;
    ops_waiting.push_back(op);
  endtask

  // operand mix: full random, small, extremes, powers of two, spread magnitudes
  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4: v = $urandom_range(0, 15);
      5: v = ~($urandom_range(0, 15));
      6: v = {{(W-1){1'b0}}, 1'b1} << $urandom_range(0, W - 1);
      7: begin
        case ($urandom_range(0, 4))
          0: v = INT_MIN;
          1: v = INT_MAX;
          2: v = MINUS_ONE;
          3: v = '0;
          default: v = 1;
        endcase
      end
      8: v = $urandom() >> $urandom_range(0, W - 1);
      default: v = ~($urandom() >> $urandom_range(0, W - 1)) + 1'b1;
    endcase
    return v;
  endfunction

  task automatic add_random(bit quiet);
    logic [W-1:0] dvs;
    dvs = pick_operand();
    // exact multiples now and then
    if ($urandom_range(0, 7) == 0)
      add_item(dvs * $urandom_range(0, 1000), dvs, quiet);
    else
      add_item(pick_operand(), dvs, quiet);
  endtask

  task automatic wait_for_drain();
    while (ops_waiting.size() != 0 || in_valid || quotients_due.size() != 0)
      @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sender: presents queued items at the falling edge, with random gaps
  always @(negedge clk) begin : driver
    div_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (ops_waiting.size() != 0) begin
        if (!ops_waiting[0].quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 19) - 1;
          in_valid <= 1'b0;
        end else begin
          op = ops_waiting.pop_front();
          cur_quiet = op.quiet;
          dividend <= op.dvd;
          divisor <= op.dvs;
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall bursts, none while quiet items are flowing
  always @(negedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!cur_quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check accepted quotients, then record newly accepted items
  always @(posedge clk) begin : monitor
    quotient_due_t due;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (quotients_due.size() == 0) begin
        report_mismatch("unexpected quotient", '0, '0, quotient, '0);
      end else begin
        due = quotients_due.pop_front();
        if (quotient !== due.quo)
          report_mismatch("quotient", due.dvd, due.dvs, quotient, due.quo);
      end
    end
    in_taken = !rst && in_valid && in_stall === 1'b0;
    if (in_taken) begin
      due.dvd = dividend;
      due.dvs = divisor;
      due.quo = predict_quotient(dividend, divisor);
      quotients_due.push_back(due);
    end
  end

  // stimulus and end of run
  initial begin
    bit quiet;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    dividend = '0;
    divisor = '0;
    in_taken = 1'b0;
    cur_quiet = 1'b0;
    gap_left = 0;
    stall_left = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero divisor, overflow, sign combinations, full negative magnitude
    add_item(0, 1, 0);
    add_item(1, 1, 0);
    add_item(INT_MAX, 1, 0);
    add_item(INT_MIN, 1, 0);
    add_item(INT_MIN, MINUS_ONE, 0);
    add_item(INT_MAX, MINUS_ONE, 0);
    add_item(INT_MIN, 0, 0);
    add_item(0, 0, 0);
    add_item(5, 0, 0);
    add_item(-32'sd5, 0, 0);
    add_item(INT_MAX, 0, 0);
    add_item(INT_MIN, INT_MIN, 0);
    add_item(INT_MAX, INT_MAX, 0);
    add_item(INT_MAX, INT_MIN, 0);
    add_item(INT_MIN, INT_MAX, 0);
    add_item(7, 2, 0);
    add_item(-32'sd7, 2, 0);
    add_item(7, -32'sd2, 0);
    add_item(-32'sd7, -32'sd2, 0);
    add_item(INT_MIN, 2, 0);
    add_item(1, INT_MIN, 0);
    add_item(MINUS_ONE, 1, 0);
    add_item(MINUS_ONE, MINUS_ONE, 0);
    add_item(32'h5555_5555, 32'haaaa_aaaa, 0);
    wait_for_drain();

    // random, idling on or off per segment
    for (int seg = 0; seg < 4; seg++) begin
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 100; n++) add_random(quiet);
    end
    // hold off until the pipeline has emptied
    wait_for_drain();
    for (int seg = 0; seg < 5; seg++) begin
      quiet = (seg == 4) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 100; n++) add_random(quiet);
    end
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sidu_pkg.sv
rtl/signed_int32_divider_unit.sv
rtl/sidu_checker.sv
dv/tb_signed_int32_divider_unit.sv
